// File: design/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants for the linear probing hash table: word
// formats, opcodes, status codes, config register indexes and sequencer states.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int ADDR_W_MAX = 16;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 4;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_BAD_KEY   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LOG2 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_KEY     = 4'd1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value_in;
    } lph_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic [1:0]         status;
    } lph_out_t;

    // one write port and one read port of the slot store
    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W_MAX-1:0] wr_addr;
        logic [KEY_W-1:0]      wr_key;
        logic [VALUE_W-1:0]    wr_value;
        logic [ADDR_W_MAX-1:0] rd_addr;
    } lph_mem_req_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_PROBE,
        S_RESP
    } lph_state_t;

endpackage

// File: design/lph_store.sv
// ----------------------------------------------------------------------------
// lph_store
// Key and value slot memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lph_store
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic               aclk,
    input  lph_mem_req_t       mem_req,
    output logic [((KEY_BITS < KEY_W) ? KEY_BITS : KEY_W)-1:0] rd_key,
    output logic [VALUE_W-1:0] rd_value
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    logic [KW-1:0]      key_mem   [TABLE_DEPTH];
    logic [VALUE_W-1:0] value_mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            key_mem[mem_req.wr_addr[AW-1:0]]   <= mem_req.wr_key[KW-1:0];
            value_mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_value;
        end
    end

    always_ff @(posedge aclk) begin
        rd_key   <= key_mem[mem_req.rd_addr[AW-1:0]];
        rd_value <= value_mem[mem_req.rd_addr[AW-1:0]];
    end

endmodule

// File: design/lph_ctrl.sv
// ----------------------------------------------------------------------------
// lph_ctrl
// Probe sequencer: hashes the key, walks the slots one per cycle through the
// shared key compare, commits the update and holds the result word.
// ----------------------------------------------------------------------------
module lph_ctrl
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lph_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lph_out_t           m_data,
    input  logic [3:0]         capacity_log2,
    input  logic [((KEY_BITS < KEY_W) ? KEY_BITS : KEY_W)-1:0] empty_key,
    output lph_mem_req_t       mem_req,
    input  logic [((KEY_BITS < KEY_W) ? KEY_BITS : KEY_W)-1:0] rd_key,
    input  logic [VALUE_W-1:0] rd_value
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int KW     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int LG_MAX = $clog2(TABLE_DEPTH + 1) - 1;
    localparam logic [AW-1:0] HM_LO    = AW'(HASH_MULT);
    localparam logic [AW-1:0] LAST_ROW = AW'(TABLE_DEPTH - 1);

    lph_state_t state_reg, state_next;

    logic [1:0]         op_reg, op_next;
    logic [KW-1:0]      key_reg, key_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [AW-1:0]      prod_reg, prod_next;
    logic [AW-1:0]      mask_reg, mask_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [AW-1:0]      left_reg, left_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    lph_out_t           m_data_reg, m_data_next;

    logic [KW-1:0]   key_in;
    logic [AW-1:0]   key_lo;
    logic [AW-1:0]   prod_w;
    logic [4:0]      lg;
    logic [AW-1:0]   mask_in;
    logic [AW-1:0]   home_slot;
    logic [AW-1:0]   next_slot;
    logic            key_hit;
    logic            key_empty;
    logic            out_free;

    assign key_in   = s_data.key[KW-1:0];
    assign key_lo   = AW'(key_in);
    // only the low address bits of the product ever reach the slot index
    assign prod_w   = key_lo * HM_LO;
    assign out_free = !m_valid_reg || m_ready;

    // slots in use: zero acts as one, clamp to the largest power of two that fits
    always_comb begin
        lg = {1'b0, capacity_log2};
        if (lg == 5'd0) begin
            lg = 5'd1;
        end
        if (lg > 5'(LG_MAX)) begin
            lg = 5'(LG_MAX);
        end
        for (int i = 0; i < AW; i++) begin
            mask_in[i] = (5'(i) < lg);
        end
    end

    assign home_slot = prod_reg & mask_reg;
    assign next_slot = (slot_reg + AW'(1)) & mask_reg;
    assign key_hit   = (rd_key == key_reg);
    assign key_empty = (rd_key == empty_key);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        prod_reg       <= prod_next;
        mask_reg       <= mask_next;
        slot_reg       <= slot_next;
        left_reg       <= left_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        prod_next       = prod_reg;
        mask_next       = mask_reg;
        slot_next       = slot_reg;
        left_next       = left_reg;
        clr_addr_next   = clr_addr_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        s_ready         = 1'b0;
        mem_req         = '0;
        mem_req.rd_addr = ADDR_W_MAX'(slot_reg);

        unique case (state_reg)
            S_CLEAR: begin
                mem_req.wr_en    = 1'b1;
                mem_req.wr_addr  = ADDR_W_MAX'(clr_addr_reg);
                mem_req.wr_key   = '1;
                mem_req.wr_value = '0;
                clr_addr_next    = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ROW) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next         = s_data.opcode;
                    key_next        = key_in;
                    val_next        = s_data.value_in;
                    prod_next       = prod_w;
                    mask_next       = mask_in;
                    res_value_next  = '0;
                    res_status_next = STAT_DONE;
                    if (key_in == empty_key) begin
                        res_status_next = STAT_BAD_KEY;
                        state_next      = S_RESP;
                    end else begin
                        case (s_data.opcode) inside
                            OP_INSERT, OP_LOOKUP, OP_DELETE: state_next = S_READ;
                            default:                         state_next = S_RESP;
                        endcase
                    end
                end
            end
            S_READ: begin
                mem_req.rd_addr = ADDR_W_MAX'(home_slot);
                slot_next       = home_slot;
                left_next       = mask_reg;
                state_next      = S_PROBE;
            end
            S_PROBE: begin
                // fetch the following slot ahead, dropped if this one ends the walk
                mem_req.rd_addr = ADDR_W_MAX'(next_slot);
                mem_req.wr_addr = ADDR_W_MAX'(slot_reg);
                if (key_hit) begin
                    res_status_next = STAT_DONE;
                    state_next      = S_RESP;
                    case (op_reg)
                        OP_INSERT: begin
                            mem_req.wr_en    = 1'b1;
                            mem_req.wr_key   = KEY_W'(key_reg);
                            mem_req.wr_value = val_reg;
                        end
                        OP_LOOKUP: begin
                            res_value_next = rd_value;
                        end
                        default: begin
                            mem_req.wr_en    = 1'b1;
                            mem_req.wr_key   = KEY_W'(empty_key);
                            mem_req.wr_value = '0;
                        end
                    endcase
                end else if (key_empty) begin
                    state_next = S_RESP;
                    if (op_reg == OP_INSERT) begin
                        mem_req.wr_en    = 1'b1;
                        mem_req.wr_key   = KEY_W'(key_reg);
                        mem_req.wr_value = val_reg;
                        res_status_next  = STAT_DONE;
                    end else begin
                        res_status_next = STAT_NOT_FOUND;
                    end
                end else if (left_reg == '0) begin
                    state_next      = S_RESP;
                    res_status_next = (op_reg == OP_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
                end else begin
                    slot_next = next_slot;
                    left_next = left_reg - AW'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.value_out = res_value_reg;
                    m_data_next.status    = res_status_reg;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_write_only_when_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == S_CLEAR || state_reg == S_PROBE))
        else $error("slot store written outside clear or probe");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE) |-> ((slot_reg & ~mask_reg) == '0))
        else $error("probe slot outside capacity");

    a_accept_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_READ || state_reg == S_RESP))
        else $error("accepted word did not start a lookup or answer");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result word raised outside response state");
`endif

endmodule

// File: design/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key/value table with linear probing and a config port.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot store once, one slot per clock, and
// s_ready stays low until the sweep is done. Each word is then taken and
// hashed, its home slot is addressed, the slots are probed one per clock
// through the single key comparator (between one and capacity slots), and
// the result is handed to the output register once that register is free.
// A key equal to the empty marker or an unused opcode skips the probing. The
// probe walk is set by the one read port of the slot memory. A new word is
// taken while the previous result still waits on m_ready.
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lph_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lph_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    logic [3:0]         capacity_log2_reg;
    logic [KW-1:0]      empty_key_reg;
    lph_mem_req_t       mem_req;
    logic [KW-1:0]      rd_key;
    logic [VALUE_W-1:0] rd_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_log2_reg <= 4'd10;
            empty_key_reg     <= '1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CAPACITY_LOG2: capacity_log2_reg <= cfg_data[3:0];
                CFG_EMPTY_KEY:     empty_key_reg     <= cfg_data[KW-1:0];
                default: begin
                end
            endcase
        end
    end

    lph_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .capacity_log2 (capacity_log2_reg),
        .empty_key     (empty_key_reg),
        .mem_req       (mem_req),
        .rd_key        (rd_key),
        .rd_value      (rd_value)
    );

    lph_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_store (
        .aclk     (aclk),
        .mem_req  (mem_req),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

endmodule
